### hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Request and status codes and the operation that steps the row of cells.
// ----------------------------------------------------------------------------
package pls_pkg;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_DUMP   = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INSERT,
        CO_DELETE,
        CO_ROTATE,
        CO_MATCH
    } t_cell_op;

    localparam int DATA_W   = 32;
    localparam int FIELD_W  = 5;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 48;

endpackage

### hw/rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed 32-bit values
// Insert, delete, search and dump on a row of shifting cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells that shift toward or away from the
// insert or delete position as a request is accepted. Clear, insert, delete
// and unused request codes give one beat, loaded into the output register as
// the request is accepted. A search has every cell compare its element into
// a match register, and then picks the lowest matching index once the output
// register is free. Once a dump is accepted, it gives one beat per stored
// element, one per cycle while the output register is free, by rotating the
// row past cell zero; an empty dump gives one beat as it is accepted.
// The next request is taken once the last beat of the current one is in the
// output register and that register is empty or being read, so a stalled
// output holds the input off. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // position[4:0], value[36:5]
    input  logic [2:0]        s_axis_tuser,   // req_type[2:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // status[2:0], result_value[34:3],
                                              // result_index[39:35],
                                              // element_count[44:40]
    output logic              m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DUMP
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_dcnt, n_dcnt;
    logic               r_ovalid;
    logic [DATA_W-1:0]  r_key;
    t_status            r_ostatus, n_status;
    logic [DATA_W-1:0]  r_ovalue, n_value;
    logic [FIELD_W-1:0] r_oindex, n_index;
    logic [FIELD_W-1:0] r_ocount;
    logic               r_olast, n_last;

    logic               s_fire;
    logic               out_free;
    logic               ld;
    t_req               in_req;
    logic [FIELD_W-1:0] in_pos;
    logic [DATA_W-1:0]  in_val;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      count_ext;
    logic [CW-1:0]      pos_cw;
    t_cell_op           cell_op;
    logic               dump_last;

    logic [DATA_W-1:0]  cell_data [0:DEPTH-1];
    logic [DEPTH-1:0]   m_vec;
    logic [DEPTH-1:0]   m_first;
    logic [CW-1:0]      first_idx;

    assign in_req    = t_req'(s_axis_tuser);
    assign in_pos    = s_axis_tdata[FIELD_W-1:0];
    assign in_val    = s_axis_tdata[FIELD_W+DATA_W-1:FIELD_W];
    assign pos_ext   = PW'(in_pos);
    assign count_ext = PW'(r_count);
    assign pos_cw    = CW'(pos_ext);

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;
        if (g == 0) begin : g_first
            assign prev_d = in_val;
        end else begin : g_mid
            assign prev_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign next_d = cell_data[g];
        end else begin : g_inner
            assign next_d = cell_data[g+1];
        end
        pls_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (pos_cw),
            .i_count (r_count),
            .i_key   (in_val),
            .i_prev  (prev_d),
            .i_next  (next_d),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g]),
            .o_match (m_vec[g])
        );
    end

    assign m_first = m_vec & (~m_vec + 1'b1);

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (m_first[i]) begin
                first_idx = first_idx | CW'(i);
            end
        end
    end

    assign dump_last = ((r_dcnt + 1'b1) == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_dcnt   = r_dcnt;
        cell_op  = CO_HOLD;
        ld       = 1'b0;
        n_status = ST_OK;
        n_value  = '0;
        n_index  = '0;
        n_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    case (in_req)
                        REQ_CLEAR: begin
                            ld      = 1'b1;
                            n_count = '0;
                        end
                        REQ_INSERT: begin
                            ld = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else if (pos_ext > count_ext) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                cell_op = CO_INSERT;
                                n_count = r_count + 1'b1;
                                n_index = in_pos;
                            end
                        end
                        REQ_DELETE: begin
                            ld = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_ext >= count_ext) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                cell_op = CO_DELETE;
                                n_count = r_count - 1'b1;
                                n_value = cell_data[pos_cw[IW-1:0]];
                                n_index = in_pos;
                            end
                        end
                        REQ_SEARCH: begin
                            cell_op = CO_MATCH;
                            n_state = S_SEARCH;
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                ld       = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                                n_dcnt  = '0;
                            end
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (out_free) begin
                    ld      = 1'b1;
                    n_state = S_IDLE;
                    if (|m_vec) begin
                        n_value = r_key;
                        n_index = FIELD_W'(first_idx);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    ld      = 1'b1;
                    cell_op = CO_ROTATE;
                    n_value = cell_data[0];
                    n_index = FIELD_W'(r_dcnt);
                    n_last  = dump_last;
                    n_dcnt  = r_dcnt + 1'b1;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dcnt  <= n_dcnt;
            if (ld) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_key <= in_val;
        end
        if (ld) begin
            r_ostatus <= n_status;
            r_ovalue  <= n_value;
            r_oindex  <= n_index;
            r_ocount  <= FIELD_W'(n_count);
            r_olast   <= n_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'b000, r_ocount, r_oindex, r_ovalue, r_ostatus};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count exceeds the list depth");

    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_dcnt < r_count))
        else $error("dump index runs past the stored elements");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_req == REQ_INSERT && r_count != FULL_CNT
         && pos_ext <= count_ext) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the list");

    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && out_free) |=> (r_state == S_IDLE && r_ovalid))
        else $error("search did not deliver its beat");

endmodule

### hw/rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list
// Holds one element, takes a neighbor's, the new key or the head element on
// insert, delete and rotate, and records whether it matches the search key.
// ----------------------------------------------------------------------------
module pls_cell import pls_pkg::*; #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [CW-1:0]     i_pos,
    input  logic [CW-1:0]     i_count,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_prev,
    input  logic [DATA_W-1:0] i_next,
    input  logic [DATA_W-1:0] i_head,
    output logic [DATA_W-1:0] o_data,
    output logic              o_match
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_match;
    logic              n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        case (i_op)
            CO_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_data = i_prev;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_key;
                end
            end
            CO_DELETE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_next;
                end
            end
            CO_ROTATE: begin
                if (NXT_IDX == i_count) begin
                    n_data = i_head;
                end else if (MY_IDX < i_count) begin
                    n_data = i_next;
                end
            end
            CO_MATCH: begin
                n_match = (r_data == i_key) && (MY_IDX < i_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list store
// Streams clear, insert, delete, search, dump and unused request codes into
// the block with random gaps and back-pressure. A scoreboard keeps its own
// copy of the list, predicts every result beat and checks each one as it
// leaves the block.
// ----------------------------------------------------------------------------
module testbench;
    import pls_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int POS_MAX       = 31;
    localparam int REQ_CODE_MAX  = 7;
    localparam int RANDOM_ITEMS  = 410;
    localparam int DRAIN_CYCLES  = 40;
    localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_ONES = 32'hffff_ffff;

    typedef struct packed {
        t_status              status;
        logic [DATA_W-1:0]    value;
        logic [FIELD_W-1:0]   index;
        logic [FIELD_W-1:0]   count;
        logic                 last;
    } t_beat;

    class list_scoreboard;
        logic [DATA_W-1:0] cells [LIST_DEPTH];
        int                fill;
        t_beat             expected [$];
        int                errors;

        function void expect_beat(t_status st, logic [DATA_W-1:0] v, int idx, bit is_last);
            t_beat b;
            b.status = st;
            b.value  = v;
            b.index  = idx[FIELD_W-1:0];
            b.count  = fill[FIELD_W-1:0];
            b.last   = is_last;
            expected.push_back(b);
        endfunction

        function void note_request(logic [2:0] req, logic [FIELD_W-1:0] pos,
                                   logic [DATA_W-1:0] v);
            int hit;
            int p;
            logic [DATA_W-1:0] removed;
            p = int'(pos);
            case (req)
                REQ_CLEAR: begin
                    fill = 0;
                    expect_beat(ST_OK, '0, 0, 1'b1);
                end
                REQ_INSERT: begin
                    if (fill >= LIST_DEPTH) begin
                        expect_beat(ST_FULL, '0, 0, 1'b1);
                    end else if (p > fill) begin
                        expect_beat(ST_BAD_POS, '0, 0, 1'b1);
                    end else begin
                        for (int i = fill; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = v;
                        fill++;
                        expect_beat(ST_OK, '0, p, 1'b1);
                    end
                end
                REQ_DELETE: begin
                    if (fill == 0) begin
                        expect_beat(ST_EMPTY, '0, 0, 1'b1);
                    end else if (p >= fill) begin
                        expect_beat(ST_BAD_POS, '0, 0, 1'b1);
                    end else begin
                        removed = cells[p];
                        for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                        expect_beat(ST_OK, removed, p, 1'b1);
                    end
                end
                REQ_SEARCH: begin
                    hit = -1;
                    for (int i = fill - 1; i >= 0; i--) begin
                        if (cells[i] == v) hit = i;
                    end
                    if (hit < 0) expect_beat(ST_NOT_FOUND, '0, 0, 1'b1);
                    else expect_beat(ST_OK, v, hit, 1'b1);
                end
                REQ_DUMP: begin
                    if (fill == 0) begin
                        expect_beat(ST_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++)
                            expect_beat(ST_OK, cells[i], i, i + 1 == fill);
                    end
                end
                default: begin
                    expect_beat(ST_OK, '0, 0, 1'b1);
                end
            endcase
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_beat(t_beat got);
            t_beat want;
            if (expected.size() == 0) begin
                report($sformatf("beat with nothing pending, status %0d value %h",
                                 got.status, got.value));
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.value !== want.value)
                report($sformatf("value %h, want %h", got.value, want.value));
            if (got.index !== want.index)
                report($sformatf("index %0d, want %0d", got.index, want.index));
            if (got.count !== want.count)
                report($sformatf("count %0d, want %0d", got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;   // position[4:0], value[36:5]
    logic [2:0]        s_axis_tuser  = '0;   // req_type[2:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;         // status, value, index, count
    logic              m_axis_tlast;

    list_scoreboard sb;
    bit             calm = 1'b0;
    int             requests_sent = 0;

    positional_list_store #(.DEPTH(LIST_DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL positional_list_store");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata[FIELD_W-1:0],
                            s_axis_tdata[FIELD_W+DATA_W-1:FIELD_W]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[2:0]);
            got.value  = m_axis_tdata[34:3];
            got.index  = m_axis_tdata[39:35];
            got.count  = m_axis_tdata[44:40];
            got.last   = m_axis_tlast;
            sb.check_beat(got);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30) return $urandom_range(0, 7);
        if (r < 34) return VAL_MIN;
        if (r < 38) return VAL_MAX;
        if (r < 40) return VAL_ONES;
        return $urandom;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // has been accepted.
    task automatic send(int req, int pos, logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req[2:0];
        s_axis_tdata  <= {{(IN_DW-FIELD_W-DATA_W){1'b0}}, v, pos[FIELD_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        requests_sent++;
    endtask

    initial begin
        int shape;
        int r;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(REQ_DUMP,   0, '0);
        send(REQ_DELETE, 0, '0);
        send(REQ_SEARCH, 0, VAL_MAX);
        send(REQ_INSERT, 1, 32'd9);
        send(REQ_INSERT, 0, VAL_MIN);
        send(REQ_INSERT, 1, VAL_MAX);
        send(REQ_INSERT, 0, VAL_ONES);
        send(REQ_INSERT, 3, VAL_ONES);
        send(REQ_INSERT, 2, '0);
        send(REQ_SEARCH, 0, VAL_ONES);
        send(REQ_SEARCH, 0, VAL_MAX);
        send(REQ_SEARCH, 0, 32'd12345);
        send(REQ_DELETE, 5, '0);
        send(REQ_DELETE, POS_MAX, '0);
        send(REQ_DELETE, 1, '0);
        send(REQ_DELETE, 3, '0);
        send(REQ_DUMP,   0, '0);
        for (int c = REQ_DUMP + 1; c <= REQ_CODE_MAX; c++)
            send(c, POS_MAX, VAL_ONES);
        send(REQ_CLEAR,  0, '0);
        send(REQ_DUMP,   0, '0);
        send(REQ_SEARCH, 0, '0);

        requests_sent = 0;
        while (requests_sent < RANDOM_ITEMS) begin
            calm  = requests_sent >= 150 && requests_sent < 230;
            shape = $urandom_range(99);
            if (shape < 60) begin
                repeat ($urandom_range(4, 12)) begin
                    r = $urandom_range(99);
                    if (r < 40 && sb.fill < LIST_DEPTH || r < 70 && sb.fill == 0) begin
                        send(REQ_INSERT, $urandom_range(0, sb.fill), pick_value());
                    end else if (r < 70) begin
                        send(REQ_DELETE, $urandom_range(0, sb.fill - 1), '0);
                    end else if (r < 90) begin
                        if (sb.fill > 0 && $urandom_range(1))
                            send(REQ_SEARCH, $urandom_range(0, POS_MAX),
                                 sb.cells[$urandom_range(0, sb.fill - 1)]);
                        else
                            send(REQ_SEARCH, $urandom_range(0, POS_MAX), pick_value());
                    end else begin
                        send(REQ_DUMP, $urandom_range(0, POS_MAX), $urandom);
                    end
                end
            end else if (shape < 75) begin
                while (sb.fill < LIST_DEPTH)
                    send(REQ_INSERT, $urandom_range(0, sb.fill), pick_value());
                send(REQ_INSERT, $urandom_range(0, POS_MAX), pick_value());
                send(REQ_DUMP, 0, '0);
                repeat ($urandom_range(1, 4))
                    send(REQ_DELETE, $urandom_range(0, sb.fill - 1), '0);
            end else if (shape < 90) begin
                repeat ($urandom_range(1, 4))
                    send($urandom_range(0, REQ_CODE_MAX), $urandom_range(0, POS_MAX),
                         $urandom);
            end else begin
                send(REQ_CLEAR, $urandom_range(0, POS_MAX), $urandom);
                send(REQ_DUMP, 0, '0);
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0)
            $display("PASS positional_list_store");
        else
            $display("FAIL positional_list_store");
        $finish;
    end

endmodule
